>>> rtl/mfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared definitions for the monochrome frame buffer draw/refresh core:
// command codes, panel command bytes, controller/datapath command and status.
// No dependencies.

package mfb_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Panel command bytes sent ahead of each page
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD   = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

  typedef enum logic [2:0] {
    CMD_POINT   = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_REFRESH = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_code_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic sweep_step;
    logic fill_rd;
    logic fill_wr;
    logic tick_rd;
    logic out_load;
    logic refresh_start;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic draw_empty;
    logic sweep_last;
    logic walk_last;
    logic refresh_active;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/mfb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the frame buffer core: draw/tick input
// channel and panel byte output channel. No dependencies.

interface mfb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] x_a;
  logic [7:0] y_a;
  logic [7:0] x_b;
  logic [7:0] y_b;
  logic       pixel_on;

  modport source (output valid, cmd, x_a, y_a, x_b, y_b, pixel_on, input ready);
  modport sink   (input valid, cmd, x_a, y_a, x_b, y_b, pixel_on, output ready);
endinterface

interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

`default_nettype wire

>>> rtl/mono_framebuffer_draw_refresh_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the monochrome page-mode frame buffer: draws points and
// rectangles into the frame store and streams it to the panel byte by byte.
// Depends on mfb_pkg, mfb_if, mfb_ctrl, mfb_datapath.
//
//   Channel  Dir  Handshake    Payload
//   in_ch    in   valid/ready  cmd, x_a, y_a, x_b, y_b, pixel_on
//   out_ch   out  valid/ready  out_byte, is_data, last
//
// Point: accept, then a read and a write of one store byte.
// Fill: accept, then one read-modify-write on the frame store per store byte
//   covered, then the refresh starts.
// Clear: one store byte zeroed per cycle across all COLUMNS*PAGES bytes.
// Tick: accept, store read, output load; a full output register
//   that is not drained stalls the load and holds in_ch.ready low.
// Reset runs the same zeroing sweep over all COLUMNS*PAGES store bytes
//   (1024 at defaults), with in_ch.ready low.

module mono_framebuffer_draw_refresh_core #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = mfb_pkg::PAGES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  mfb_in_if.sink     in_ch,
  mfb_out_if.source  out_ch
);
  import mfb_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .cmd      (in_ch.cmd),
    .in_ready (in_ch.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  mfb_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cmd       (in_ch.cmd),
    .x_a       (in_ch.x_a),
    .y_a       (in_ch.y_a),
    .x_b       (in_ch.x_b),
    .y_b       (in_ch.y_b),
    .pixel_on  (in_ch.pixel_on),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .is_data   (out_ch.is_data),
    .last      (out_ch.last)
  );

endmodule

`default_nettype wire

>>> rtl/mfb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine for the frame buffer core: clearing sweep,
// read-modify-write walk for points and rectangles, tick byte issue.
// Depends on mfb_pkg.

module mfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          cmd,
  output logic                in_ready,
  input  mfb_pkg::dp_status_t status,
  output mfb_pkg::dp_ctrl_t   ctrl
);
  import mfb_pkg::*;

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_WR    = 6'b001000,
    ST_TRD   = 6'b010000,
    ST_TOUT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   draw_fill, draw_fill_next;
  logic   clear_pending, clear_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      draw_fill     <= 1'b0;
      clear_pending <= 1'b0;
    end else begin
      state         <= state_next;
      draw_fill     <= draw_fill_next;
      clear_pending <= clear_pending_next;
    end
  end

  always_comb begin
    state_next         = state;
    draw_fill_next     = draw_fill;
    clear_pending_next = clear_pending;
    ctrl               = '0;
    in_ready           = 1'b0;
    case (state)
      ST_SWEEP: begin
        ctrl.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next         = ST_IDLE;
          ctrl.refresh_start = clear_pending;
          clear_pending_next = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.refresh_active) begin
            // only ticks count during a refresh; drop the rest
            if (cmd == CMD_TICK) begin
              state_next = ST_TRD;
            end
          end else begin
            case (cmd)
              CMD_POINT: begin
                ctrl.load_item = 1'b1;
                draw_fill_next = 1'b0;
                if (!status.draw_empty) begin
                  state_next = ST_RD;
                end
              end
              CMD_FILL: begin
                ctrl.load_item = 1'b1;
                draw_fill_next = 1'b1;
                if (status.draw_empty) begin
                  ctrl.refresh_start = 1'b1;
                end else begin
                  state_next = ST_RD;
                end
              end
              CMD_CLEAR: begin
                clear_pending_next = 1'b1;
                state_next         = ST_SWEEP;
              end
              CMD_REFRESH: begin
                ctrl.refresh_start = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_RD: begin
        ctrl.fill_rd = 1'b1;
        state_next   = ST_WR;
      end
      ST_WR: begin
        ctrl.fill_wr = 1'b1;
        if (status.walk_last) begin
          state_next         = ST_IDLE;
          ctrl.refresh_start = draw_fill;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_TRD: begin
        ctrl.tick_rd = 1'b1;
        state_next   = ST_TOUT;
      end
      ST_TOUT: begin
        // hold the byte until the output register frees up
        if (status.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mfb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath for the frame buffer core: frame store memory, draw walk counters
// and pixel masks, refresh counters and the output register.
// Depends on mfb_pkg.

module mfb_datapath #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = mfb_pkg::PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mfb_pkg::dp_ctrl_t   ctrl,
  output mfb_pkg::dp_status_t status,
  input  logic [2:0]          cmd,
  input  logic [7:0]          x_a,
  input  logic [7:0]          y_a,
  input  logic [7:0]          x_b,
  input  logic [7:0]          y_b,
  input  logic                pixel_on,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                is_data,
  output logic                last
);
  import mfb_pkg::*;

  localparam int ROWS  = PAGES * 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(COLUMNS + 3);

  localparam logic [7:0]    X_MAX      = 8'(COLUMNS - 1);
  localparam logic [7:0]    Y_MAX      = 8'(ROWS - 1);
  localparam logic [PW-1:0] PAGE_LAST  = PW'(PAGES - 1);
  localparam logic [BW-1:0] POS_LAST   = BW'(COLUMNS + 2);
  localparam logic [BW-1:0] POS_DATA   = BW'(3);
  localparam logic [BW-1:0] POS_CMD_B  = BW'(1);
  localparam logic [BW-1:0] POS_CMD_C  = BW'(2);
  localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] PAGE_SPAN  = AW'(PAGES);

  // Item decode
  logic [7:0]    x_end_in, y_end_in, xe, ye;
  logic [PW-1:0] p_lo_in, p_hi_in;

  always_comb begin
    x_end_in = (cmd == CMD_POINT) ? x_a : x_b;
    y_end_in = (cmd == CMD_POINT) ? y_a : y_b;
    xe       = (x_end_in > X_MAX) ? X_MAX : x_end_in;
    ye       = (y_end_in > Y_MAX) ? Y_MAX : y_end_in;
    // pages run bottom-up: higher rows live in lower page numbers
    p_lo_in  = PAGE_LAST - PW'(ye[7:3]);
    p_hi_in  = PAGE_LAST - PW'(y_a[7:3]);
  end

  // Draw walk registers
  logic [CW-1:0] col, col_end;
  logic [PW-1:0] page, page_lo, page_hi;
  logic [7:0]    y_lo, y_hi;
  logic          draw_on;

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      col     <= CW'(x_a);
      col_end <= CW'(xe);
      page    <= p_lo_in;
      page_lo <= p_lo_in;
      page_hi <= p_hi_in;
      y_lo    <= y_a;
      y_hi    <= ye;
      draw_on <= pixel_on;
    end else if (ctrl.fill_wr) begin
      if (page == page_hi) begin
        page <= page_lo;
        col  <= col + CW'(1);
      end else begin
        page <= page + PW'(1);
      end
    end
  end

  // Pixel mask for the byte under the walk
  logic [7:0] row_base, mask, rd_data, fill_data;

  always_comb begin
    row_base = 8'({PAGE_LAST - page, 3'b000});
    for (int b = 0; b < 8; b++) begin
      mask[b] = ((row_base + 8'(7 - b)) >= y_lo) && ((row_base + 8'(7 - b)) <= y_hi);
    end
    fill_data = draw_on ? (rd_data | mask) : (rd_data & ~mask);
  end

  // Refresh counters
  logic          refresh_active;
  logic [PW-1:0] page_counter;
  logic [BW-1:0] byte_position;
  logic          pos_is_data;
  logic [CW-1:0] tick_col;
  logic          final_byte;

  assign pos_is_data = (byte_position >= POS_DATA);
  assign tick_col    = CW'(byte_position - POS_DATA);
  assign final_byte  = (byte_position == POS_LAST) && (page_counter == PAGE_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_active <= 1'b0;
      page_counter   <= '0;
      byte_position  <= '0;
    end else if (ctrl.refresh_start) begin
      refresh_active <= 1'b1;
      page_counter   <= '0;
      byte_position  <= '0;
    end else if (ctrl.out_load) begin
      if (byte_position == POS_LAST) begin
        byte_position <= '0;
        if (page_counter == PAGE_LAST) begin
          page_counter   <= '0;
          refresh_active <= 1'b0;
        end else begin
          page_counter <= page_counter + PW'(1);
        end
      end else begin
        byte_position <= byte_position + BW'(1);
      end
    end
  end

  // Clearing sweep address
  logic [AW-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (ctrl.sweep_step) begin
      sweep_addr <= (sweep_addr == ADDR_LAST) ? '0 : sweep_addr + AW'(1);
    end
  end

  // Frame store: one write port, one registered read port
  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] walk_addr, tick_addr, wr_addr, rd_addr;
  logic [7:0]    wr_data;
  logic          mem_we, mem_re;

  always_comb begin
    walk_addr = AW'(col) * PAGE_SPAN + AW'(page);
    tick_addr = AW'(tick_col) * PAGE_SPAN + AW'(page_counter);
    mem_we    = ctrl.sweep_step | ctrl.fill_wr;
    wr_addr   = ctrl.sweep_step ? sweep_addr : walk_addr;
    wr_data   = ctrl.sweep_step ? 8'h00 : fill_data;
    mem_re    = ctrl.fill_rd | (ctrl.tick_rd & pos_is_data);
    rd_addr   = ctrl.fill_rd ? walk_addr : tick_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Output register
  logic [7:0] byte_sel;

  always_comb begin
    if (byte_position == '0) begin
      byte_sel = PAGE_CMD_BASE + 8'(page_counter);
    end else if (byte_position == POS_CMD_B) begin
      byte_sel = COL_LOW_CMD;
    end else if (byte_position == POS_CMD_C) begin
      byte_sel = COL_HIGH_CMD;
    end else begin
      byte_sel = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_byte <= byte_sel;
      is_data  <= pos_is_data;
      last     <= final_byte;
    end
  end

  always_comb begin
    status.draw_empty     = (x_a > xe) || (y_a > ye);
    status.sweep_last     = (sweep_addr == ADDR_LAST);
    status.walk_last      = (page == page_hi) && (col == col_end);
    status.refresh_active = refresh_active;
    status.out_free       = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> rtl/mfb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the frame buffer core, bound to the top level.
// Depends on mono_framebuffer_draw_refresh_core.

module mfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_is_data,
  input logic       out_last
);

  // The zeroing sweep blocks input right after reset
  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input accepted during reset sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_is_data) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_is_data)
    else $error("last flagged on a command byte");

  a_cmd_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_is_data |->
      (out_byte[7:4] == 4'hB) || (out_byte == 8'h00) || (out_byte == 8'h10))
    else $error("command byte outside page/column set");

endmodule

bind mono_framebuffer_draw_refresh_core mfb_checker u_mfb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .out_is_data (out_ch.is_data),
  .out_last    (out_ch.last)
);

`default_nettype wire
